>>> rtl/core/wrnp_pkg.sv
// Shared types, constants and the per-side weight rule for the weighted
// neighbor pick. No dependencies.
`default_nettype none
package wrnp_pkg;

  localparam int SIDE_COUNT = 17;
  localparam int COUNT_BITS = 16;
  localparam int SIDE_W     = $clog2(SIDE_COUNT);
  localparam int CFG_W      = 16;
  localparam int VAL_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int WEIGHT_W   = VAL_W + 2;
  localparam int TOTAL_W    = WEIGHT_W + 5;
  localparam int RV_W       = 31;
  localparam int RV_CNT_W   = $clog2(RV_W);
  localparam int SITE_W     = 8;

  localparam logic [CFG_W-1:0]  MAXD_RESET   = 16'd255;
  localparam logic [SITE_W-1:0] SITE_INVALID = 8'hFF;
  localparam logic [SITE_W-1:0] SITE_LAST    = 8'h0F;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PICK  = 1'b1;

  typedef struct packed {
    logic                  nonempty;
    logic [COUNT_BITS-1:0] distance;
    logic [COUNT_BITS-1:0] active;
    logic                  target_valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sides weighted by distance for a given start site.
  function automatic logic site_listed(input logic [3:0] site, input logic [SIDE_W-1:0] side);
    logic hit;
    hit = 1'b0;
    case (site)
      4'd2:    hit = side inside {5'd4, 5'd13, 5'd14};
      4'd3:    hit = side inside {5'd12, 5'd13, 5'd14};
      4'd4:    hit = side inside {5'd2, 5'd12, 5'd13};
      4'd12:   hit = side inside {5'd3, 5'd4, 5'd14};
      4'd13:   hit = side inside {5'd2, 5'd3, 5'd4};
      4'd14:   hit = side inside {5'd2, 5'd3, 5'd12};
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [WEIGHT_W-1:0] side_weight(
    input logic [3:0]        site,
    input logic [SIDE_W-1:0] side,
    input entry_t            e,
    input logic [CFG_W-1:0]  maxd,
    input logic              node,
    input logic              uni
  );
    logic [WEIGHT_W-1:0] plus;
    logic [WEIGHT_W-1:0] minus;
    logic [WEIGHT_W-1:0] w;
    plus  = WEIGHT_W'(maxd) + WEIGHT_W'(e.active);
    minus = WEIGHT_W'(e.distance);
    w     = '0;
    if (site == 4'd0) begin
      if (e.nonempty && (side inside {5'd2, 5'd3, 5'd4, 5'd12, 5'd13, 5'd14}))
        w = WEIGHT_W'(1);
    end else if (site inside {4'd2, 4'd3, 4'd4, 4'd12, 4'd13, 4'd14}) begin
      if (site_listed(site, side))
        w = (plus > minus) ? plus - minus : '0;
      else if (side == 5'd8 && node)
        w = plus;
      else if (side == 5'd16 && e.target_valid)
        w = WEIGHT_W'(maxd);
    end
    if (uni && w != '0)
      w = WEIGHT_W'(1);
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/wrnp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module wrnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/wrnp_div.sv
// Restoring bit-serial remainder unit: dividend mod divisor, one bit a cycle.
// Depends on wrnp_pkg.
`default_nettype none
module wrnp_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [wrnp_pkg::RV_W-1:0]     dividend,
  input  wire logic [wrnp_pkg::TOTAL_W-1:0]  divisor,
  output logic                               done,
  output logic      [wrnp_pkg::TOTAL_W-1:0]  rem
);

  logic                             busy;
  logic [wrnp_pkg::RV_CNT_W-1:0]    cnt;
  logic [wrnp_pkg::RV_W-1:0]        quo;
  logic [wrnp_pkg::TOTAL_W:0]       trial;
  logic [wrnp_pkg::TOTAL_W-1:0]     rem_next;

  // rem < divisor, so trial < 2*divisor and the difference fits back in rem
  assign trial = {rem, quo[wrnp_pkg::RV_W-1]};

  always_comb begin
    if (trial >= {1'b0, divisor})
      rem_next = wrnp_pkg::TOTAL_W'(trial - {1'b0, divisor});
    else
      rem_next = trial[wrnp_pkg::TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wrnp_pkg::RV_CNT_W'(wrnp_pkg::RV_W - 1);
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[wrnp_pkg::RV_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/weighted_random_neighbor_pick.sv
// Top level: neighbor table in RAM, weight walk, remainder unit and pick walk.
// Depends on wrnp_pkg, wrnp_ram, wrnp_div.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, mode .. random_value   | request in
//  out     | out_valid/out_ready, next_site, moved     | result out
//  cfg     | cfg_we, cfg_wdata (base weight)           | write only
//
// A table write or an invalid start site goes from accept to S_FINISH, then back to idle.
// A pick runs two walks over the 17-entry table through the RAM read port
// around a remainder (31 bit steps, plus start and done).
// A zero total ends after the first walk; the pick walk stops at the chosen side.
// One request in flight; in_ready only when idle; a stalled result holds the block.
// Reset clears the table valid bits (entries read as zero); base weight goes to 255.
`default_nettype none
module weighted_random_neighbor_pick (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              mode,
  input  wire logic [4:0]                        entry_index,
  input  wire logic                              entry_nonempty,
  input  wire logic [15:0]                       entry_distance,
  input  wire logic [15:0]                       entry_active,
  input  wire logic                              entry_target_valid,
  input  wire logic [wrnp_pkg::SITE_W-1:0]       start_site,
  input  wire logic                              at_node,
  input  wire logic                              uniform_weights,
  input  wire logic [wrnp_pkg::RV_W-1:0]         random_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [wrnp_pkg::SITE_W-1:0]       next_site,
  output logic                                   moved,
  input  wire logic                              cfg_we,
  input  wire logic [wrnp_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_DIV, S_PICK, S_FINISH} state_t;

  state_t                              state;
  logic [wrnp_pkg::SIDE_W-1:0]         cnt;
  logic                                rd_pend;
  logic [wrnp_pkg::SIDE_W-1:0]         rd_side;
  logic [3:0]                          site;
  logic                                node;
  logic                                uni;
  logic [wrnp_pkg::RV_W-1:0]           rv;
  logic [wrnp_pkg::TOTAL_W-1:0]        total;
  logic [wrnp_pkg::TOTAL_W-1:0]        run;
  logic [wrnp_pkg::TOTAL_W-1:0]        rem_val;
  logic [wrnp_pkg::SITE_W-1:0]         res_site;
  logic                                res_moved;
  logic [wrnp_pkg::CFG_W-1:0]          maxd;
  logic [wrnp_pkg::SIDE_COUNT-1:0]     valid;
  logic                                div_start;

  logic                                accept;
  logic                                wr_en;
  wrnp_pkg::entry_t                    wr_entry;
  logic [wrnp_pkg::ENTRY_W-1:0]        ram_q;
  wrnp_pkg::entry_t                    entry;
  logic [wrnp_pkg::WEIGHT_W-1:0]       w;
  logic [wrnp_pkg::TOTAL_W-1:0]        total_next;
  logic [wrnp_pkg::TOTAL_W-1:0]        run_next;
  logic                                div_done;
  logic [wrnp_pkg::TOTAL_W-1:0]        div_rem;
  logic                                last_side;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (mode == wrnp_pkg::MODE_WRITE) &&
                    (entry_index < wrnp_pkg::SIDE_W'(wrnp_pkg::SIDE_COUNT));

  always_comb begin
    wr_entry.nonempty     = entry_nonempty;
    wr_entry.distance     = wrnp_pkg::COUNT_BITS'(entry_distance);
    wr_entry.active       = wrnp_pkg::COUNT_BITS'(entry_active);
    wr_entry.target_valid = entry_target_valid;
  end

  wrnp_ram #(
    .WIDTH (wrnp_pkg::ENTRY_W),
    .DEPTH (wrnp_pkg::SIDE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_index),
    .wdata (wr_entry),
    .raddr (cnt),
    .rdata (ram_q)
  );

  // never-written entries read as the reset value (all zero)
  assign entry      = valid[rd_side] ? wrnp_pkg::entry_t'(ram_q) : '0;
  assign w          = wrnp_pkg::side_weight(site, rd_side, entry, maxd, node, uni);
  assign total_next = total + wrnp_pkg::TOTAL_W'(w);
  assign run_next   = run + wrnp_pkg::TOTAL_W'(w);
  assign last_side  = (rd_side == wrnp_pkg::SIDE_W'(wrnp_pkg::SIDE_COUNT - 1));

  wrnp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rv),
    .divisor  (total),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      maxd      <= wrnp_pkg::MAXD_RESET;
      div_start <= 1'b0;
      rd_pend   <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_we)
        maxd <= cfg_wdata;
      if (out_valid && out_ready)
        out_valid <= 1'b0;
      div_start <= 1'b0;

      // table read issue for both walks
      if (state == S_SUM || state == S_PICK) begin
        if (cnt < wrnp_pkg::SIDE_W'(wrnp_pkg::SIDE_COUNT)) begin
          cnt     <= cnt + 1'b1;
          rd_pend <= 1'b1;
          rd_side <= cnt;
        end else begin
          rd_pend <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == wrnp_pkg::MODE_WRITE) begin
              if (wr_en)
                valid[entry_index] <= 1'b1;
              res_site  <= '0;
              res_moved <= 1'b0;
              state     <= S_FINISH;
            end else if (start_site > wrnp_pkg::SITE_LAST) begin
              res_site  <= wrnp_pkg::SITE_INVALID;
              res_moved <= 1'b0;
              state     <= S_FINISH;
            end else begin
              site    <= start_site[3:0];
              node    <= at_node;
              uni     <= uniform_weights;
              rv      <= random_value;
              total   <= '0;
              cnt     <= '0;
              rd_pend <= 1'b0;
              state   <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (rd_pend) begin
            total <= total_next;
            if (last_side) begin
              rd_pend <= 1'b0;
              if (total_next == '0) begin
                res_site  <= wrnp_pkg::SITE_W'(site);
                res_moved <= 1'b0;
                state     <= S_FINISH;
              end else begin
                div_start <= 1'b1;
                state     <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rem_val <= div_rem;
            run     <= '0;
            cnt     <= '0;
            rd_pend <= 1'b0;
            state   <= S_PICK;
          end
        end
        S_PICK: begin
          if (rd_pend) begin
            run <= run_next;
            if (run_next > rem_val) begin
              rd_pend <= 1'b0;
              state   <= S_FINISH;
              if (rd_side != '0) begin
                res_site  <= wrnp_pkg::SITE_W'(rd_side);
                res_moved <= 1'b1;
              end else begin
                res_site  <= wrnp_pkg::SITE_W'(site);
                res_moved <= 1'b0;
              end
            end else if (last_side) begin
              rd_pend   <= 1'b0;
              res_site  <= wrnp_pkg::SITE_W'(site);
              res_moved <= 1'b0;
              state     <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            next_site <= res_site;
            moved     <= res_moved;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Bench for weighted_random_neighbor_pick: table writes, roulette picks and
// base-weight writes checked against an in-bench predictor. Needs wrnp_pkg and the RTL.
module tb;
  import wrnp_pkg::*;

  localparam int HOLD_AT   = 60;    // result count that starts the long output hold
  localparam int LONG_HOLD = 400;
  localparam logic [SIDE_COUNT-1:0] RING_SIDES = 17'b0_0111_0000_0001_1100;
  localparam logic [5:0][SITE_W-1:0] RULE_SITES = {8'd2, 8'd3, 8'd4, 8'd12, 8'd13, 8'd14};

  typedef struct packed {
    logic                  mode;
    logic [4:0]            index;
    logic                  nonempty;
    logic [15:0]           distance;
    logic [15:0]           active;
    logic                  target_valid;
    logic [SITE_W-1:0]     start;
    logic                  node;
    logic                  uni;
    logic [RV_W-1:0]       rv;
  } request_t;

  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic              moved;
  } choice_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              out_ready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  request_t          offer = '0;
  logic              in_ready;
  logic              out_valid;
  logic [SITE_W-1:0] next_site;
  logic              moved;

  request_t pending[$];
  choice_t  expected_choices[$];
  choice_t  due;
  int       fail_count = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       result_count = 0;
  int       span;
  bit       idle_on = 1'b1;

  // predictor copy of the table and the register
  logic                  nb_nonempty [SIDE_COUNT];
  logic [COUNT_BITS-1:0] nb_distance [SIDE_COUNT];
  logic [COUNT_BITS-1:0] nb_active   [SIDE_COUNT];
  logic                  nb_valid    [SIDE_COUNT];
  logic [CFG_W-1:0]      maxd_model = MAXD_RESET;

  weighted_random_neighbor_pick dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .mode               (offer.mode),
    .entry_index        (offer.index),
    .entry_nonempty     (offer.nonempty),
    .entry_distance     (offer.distance),
    .entry_active       (offer.active),
    .entry_target_valid (offer.target_valid),
    .start_site         (offer.start),
    .at_node            (offer.node),
    .uniform_weights    (offer.uni),
    .random_value       (offer.rv),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .next_site          (next_site),
    .moved              (moved),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int idle_span();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic choice_t choose_site(input request_t q);
    logic [WEIGHT_W-1:0]   w [SIDE_COUNT];
    logic [WEIGHT_W-1:0]   plus;
    logic [TOTAL_W-1:0]    total;
    logic [TOTAL_W-1:0]    run;
    logic [TOTAL_W-1:0]    slot;
    logic [2:0][4:0]       trio;
    logic                  has_rule;
    choice_t               c;
    c.site   = q.start;
    c.moved  = 1'b0;
    total    = '0;
    run      = '0;
    trio     = '0;
    has_rule = 1'b1;
    if (q.start > SITE_LAST) begin
      c.site = SITE_INVALID;
      return c;
    end
    case (q.start)
      8'd2:    trio = {5'd4, 5'd13, 5'd14};
      8'd3:    trio = {5'd12, 5'd13, 5'd14};
      8'd4:    trio = {5'd2, 5'd12, 5'd13};
      8'd12:   trio = {5'd3, 5'd4, 5'd14};
      8'd13:   trio = {5'd2, 5'd3, 5'd4};
      8'd14:   trio = {5'd2, 5'd3, 5'd12};
      default: has_rule = 1'b0;
    endcase
    for (int i = 0; i < SIDE_COUNT; i++) w[i] = '0;
    if (q.start == '0) begin
      for (int i = 0; i < SIDE_COUNT; i++)
        if (RING_SIDES[i] && nb_nonempty[i]) w[i] = WEIGHT_W'(1);
    end else if (has_rule) begin
      for (int k = 0; k < 3; k++) begin
        plus = WEIGHT_W'(maxd_model) + WEIGHT_W'(nb_active[trio[k]]);
        w[trio[k]] = (plus > WEIGHT_W'(nb_distance[trio[k]])) ?
                     plus - WEIGHT_W'(nb_distance[trio[k]]) : '0;
      end
      if (q.node) w[8] = WEIGHT_W'(maxd_model) + WEIGHT_W'(nb_active[8]);
      if (nb_valid[16]) w[16] = WEIGHT_W'(maxd_model);
    end
    for (int i = 0; i < SIDE_COUNT; i++) begin
      if (q.uni && w[i] != '0) w[i] = WEIGHT_W'(1);
      total = total + TOTAL_W'(w[i]);
    end
    if (total == '0) return c;
    slot = TOTAL_W'(q.rv % RV_W'(total));
    for (int i = 0; i < SIDE_COUNT; i++) begin
      run = run + TOTAL_W'(w[i]);
      if (run > slot) begin
        if (i != 0) begin
          c.site  = SITE_W'(i);
          c.moved = 1'b1;
        end
        break;
      end
    end
    return c;
  endfunction

  // request driver: table update and expectation at acceptance, then next request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      for (int i = 0; i < SIDE_COUNT; i++) begin
        nb_nonempty[i] = 1'b0;
        nb_distance[i] = '0;
        nb_active[i]   = '0;
        nb_valid[i]    = 1'b0;
      end
    end else begin
      if (in_valid && in_ready) begin
        if (offer.mode == MODE_WRITE) begin
          if (offer.index < SIDE_COUNT) begin
            nb_nonempty[offer.index] = offer.nonempty;
            nb_distance[offer.index] = offer.distance[COUNT_BITS-1:0];
            nb_active[offer.index]   = offer.active[COUNT_BITS-1:0];
            nb_valid[offer.index]    = offer.target_valid;
          end
          expected_choices.push_back('0);
        end else begin
          expected_choices.push_back(choose_site(offer));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          offer    <= pending.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_span();
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_choices.size() == 0) begin
          $error("unexpected result: next_site %0d moved %0d", next_site, moved);
          fail_count++;
        end else begin
          due = expected_choices.pop_front();
          if (next_site !== due.site) begin
            $error("next_site: expected %0d, got %0d", due.site, next_site);
            fail_count++;
          end
          if (moved !== due.moved) begin
            $error("moved: expected %0d, got %0d", due.moved, moved);
            fail_count++;
          end
        end
      end
      if (out_valid && out_ready && result_count == HOLD_AT) begin
        out_ready  <= 1'b0;
        stall_left <= LONG_HOLD;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        span = idle_span();
        out_ready  <= (span == 0);
        stall_left <= (span == 0) ? 0 : span - 1;
      end
    end
  end

  task automatic queue_write(input logic [4:0] idx, input logic ne,
                             input logic [15:0] reach, input logic [15:0] act,
                             input logic tv);
    request_t q;
    q              = '0;
    q.mode         = MODE_WRITE;
    q.index        = idx;
    q.nonempty     = ne;
    q.distance     = reach;
    q.active       = act;
    q.target_valid = tv;
    pending.push_back(q);
  endtask

  task automatic queue_pick(input logic [SITE_W-1:0] site, input logic node,
                            input logic uni, input logic [RV_W-1:0] rv);
    request_t q;
    q       = '0;
    q.mode  = MODE_PICK;
    q.start = site;
    q.node  = node;
    q.uni   = uni;
    q.rv    = rv;
    pending.push_back(q);
  endtask

  // sampled at the falling edge so the driver has settled
  task automatic drain();
    while (pending.size() != 0 || in_valid || expected_choices.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_base_weight(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    maxd_model = value;
  endtask

  task automatic run_phase(input int count);
    request_t q;
    int       r;
    for (int n = 0; n < count; n++) begin
      q              = '0;
      q.index        = 5'($urandom_range(31));
      q.nonempty     = 1'($urandom_range(1));
      q.distance     = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023));
      q.active       = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023));
      q.target_valid = 1'($urandom_range(1));
      q.start        = 8'($urandom_range(255));
      q.node         = 1'($urandom_range(1));
      q.uni          = ($urandom_range(3) == 0);
      q.rv           = ($urandom_range(7) == 0) ? RV_W'($urandom_range(3)) : RV_W'($urandom);
      if ($urandom_range(99) < 35) begin
        q.mode = MODE_WRITE;
        if ($urandom_range(9) != 0) q.index = 5'($urandom_range(SIDE_COUNT - 1));
      end else begin
        q.mode = MODE_PICK;
        r = $urandom_range(99);
        if (r < 55)      q.start = RULE_SITES[$urandom_range(5)];
        else if (r < 70) q.start = '0;
        else if (r < 85) q.start = 8'($urandom_range(15));
        else             q.start = 8'($urandom_range(16, 255));
      end
      pending.push_back(q);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, reset base weight
    queue_pick(8'd0, 1'b0, 1'b0, '0);
    queue_pick(8'd2, 1'b0, 1'b0, '0);
    queue_pick(8'd16, 1'b1, 1'b0, '0);
    queue_pick(SITE_INVALID, 1'b1, 1'b1, '1);
    queue_pick(8'd15, 1'b1, 1'b0, 31'd5);
    queue_pick(8'd1, 1'b1, 1'b1, 31'd9);
    // out-of-range indexes are dropped
    queue_write(5'd17, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_write(5'd31, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_write(5'd0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_write(5'd4, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
    queue_write(5'd13, 1'b1, 16'h0000, 16'hFFFF, 1'b0);
    queue_write(5'd16, 1'b0, 16'h0000, 16'h0000, 1'b1);
    queue_write(5'd8, 1'b0, 16'h1234, 16'hFFFF, 1'b0);
    queue_pick(8'd2, 1'b1, 1'b0, '1);
    queue_pick(8'd2, 1'b1, 1'b1, 31'd2);
    queue_pick(8'd0, 1'b0, 1'b0, '1);
    queue_pick(8'd0, 1'b1, 1'b1, 31'd1);
    queue_pick(8'd12, 1'b0, 1'b0, '0);
    drain();
    set_base_weight(16'hFFFF);
    queue_pick(8'd13, 1'b1, 1'b0, '1);
    queue_pick(8'd14, 1'b0, 1'b0, 31'd77);
    drain();
    set_base_weight(16'h0000);
    queue_write(5'd16, 1'b0, 16'h0000, 16'h0000, 1'b0);
    queue_pick(8'd3, 1'b0, 1'b0, '1);
    queue_pick(8'd4, 1'b0, 1'b0, 31'd100);
    drain();

    set_base_weight(16'd255);
    run_phase(170);
    idle_on = 1'b0;
    set_base_weight(16'h0000);
    run_phase(170);
    idle_on = 1'b1;
    set_base_weight(16'hFFFF);
    run_phase(170);
    set_base_weight(16'($urandom));
    run_phase(170);
    set_base_weight(16'd1);
    run_phase(170);

    repeat (100) @(negedge clk);
    if (expected_choices.size() != 0) begin
      $error("%0d results never arrived", expected_choices.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
